FILE: rtl/resp_stream_parser_core_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the RESP stream parser
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef RESP_STREAM_PARSER_CORE_DEFINES_SVH
`define RESP_STREAM_PARSER_CORE_DEFINES_SVH

// Same-cycle implication.
`define RSP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("resp parser assertion failed");

// Next-cycle implication.
`define RSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("resp parser assertion failed");

`endif

FILE: rtl/rsp_pkg.sv
// ---------------------------------------------------------------------------
// RESP stream parser package
// Types, codes and character constants shared by the parser modules.
// ---------------------------------------------------------------------------
`default_nettype none

package rsp_pkg;

    localparam int STACK_DEPTH_DEF = 16;
    localparam int LEN_BITS_DEF    = 32;
    localparam int INT_W           = 64;
    localparam int LEN_OUT_W       = 32;
    localparam int DEPTH_OUT_W     = 5;

    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_ONE    = 8'h31;
    localparam logic [7:0] CH_NINE   = 8'h39;

    typedef enum logic [3:0] {
        PH_TYPE, PH_LINE, PH_SIZE, PH_SIZE_LF, PH_NIL,
        PH_NIL_CR, PH_NIL_LF, PH_END_LF, PH_BULK
    } phase_t;

    typedef enum logic [2:0] {
        EV_NONE, EV_PAYLOAD, EV_DONE, EV_OPEN, EV_ERROR
    } event_t;

    typedef enum logic [2:0] {
        K_SIMPLE, K_ERRSTR, K_INT, K_BULK, K_ARRAY
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE, ERR_TYPE, ERR_SIZE, ERR_TERM,
        ERR_INT, ERR_STACK, ERR_LENGTH, ERR_HALTED
    } err_t;

    typedef enum logic [1:0] {
        SIGN_NONE, SIGN_PLUS, SIGN_MINUS
    } sign_t;

    typedef struct packed {
        event_t                  ev;
        logic [7:0]              payload;
        kind_t                   kind;
        logic                    is_null;
        logic [INT_W-1:0]        int_value;
        logic [LEN_OUT_W-1:0]    length;
        logic [DEPTH_OUT_W-1:0]  depth;
        logic [DEPTH_OUT_W-1:0]  closed;
        logic                    msg_done;
        err_t                    err;
    } result_t;

    typedef struct packed {
        logic clear;
        logic push;
        logic complete;
    } stk_ctl_t;

    typedef struct packed {
        logic full;
        logic drained;
    } stk_stat_t;

endpackage

`default_nettype wire

FILE: rtl/resp_stream_parser_core.sv
// ---------------------------------------------------------------------------
// RESP2 stream parser core
// Parses RESP2 bytes, one event per byte, one per cycle unless stalled.
// ---------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------
//  input   | in_valid / in_ready  | command, data_byte
//  output  | out_valid / out_ready| event_res .. error_code (one per byte)
//
//  One byte per cycle sustained while the output accepts; each byte is held
//  in the input register, then parsed into the result register.
//  The nesting stack, the line accumulators and the phase update in the
//  same cycle that a byte leaves the input register.
//  A stalled output holds the result register and the input register;
//  input ready drops only when both are full. Reset is asynchronous.
// ---------------------------------------------------------------------------
`default_nettype none

`include "resp_stream_parser_core_defines.svh"

module resp_stream_parser_core #(
    parameter int STACK_DEPTH = rsp_pkg::STACK_DEPTH_DEF,
    parameter int LEN_BITS    = rsp_pkg::LEN_BITS_DEF
) (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                in_valid,
    output logic               in_ready,
    input  wire                command,
    input  wire  [7:0]         data_byte,
    output logic               out_valid,
    input  wire                out_ready,
    output logic [2:0]         event_res,
    output logic [7:0]         payload_byte,
    output logic [2:0]         value_kind,
    output logic               is_null,
    output logic signed [63:0] int_value,
    output logic [31:0]        length,
    output logic [4:0]         depth,
    output logic [4:0]         arrays_closed,
    output logic               message_done,
    output logic [2:0]         error_code
);
    import rsp_pkg::*;

    logic     s1_valid_reg, s1_valid_next;
    logic     s1_cmd_reg;
    logic [7:0] s1_byte_reg;
    logic     out_valid_reg, out_valid_next;
    result_t  res;
    result_t  res_reg;
    logic     fire;

    // Advance the parse stage when the result register is free or draining
    assign fire     = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || fire;

    assign s1_valid_next  = (in_valid && in_ready) || (s1_valid_reg && !fire);
    assign out_valid_next = fire || (out_valid_reg && !out_ready);

    rsp_engine #(
        .STACK_DEPTH (STACK_DEPTH),
        .LEN_BITS    (LEN_BITS)
    ) u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire),
        .cmd     (s1_cmd_reg),
        .byte_in (s1_byte_reg),
        .res     (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the input transaction, held while parsing stalls; load the result
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_cmd_reg  <= command;
            s1_byte_reg <= data_byte;
        end
        if (fire)
        begin
            res_reg <= res;
        end
    end

    assign out_valid     = out_valid_reg;
    assign event_res     = res_reg.ev;
    assign payload_byte  = res_reg.payload;
    assign value_kind    = res_reg.kind;
    assign is_null       = res_reg.is_null;
    assign int_value     = $signed(res_reg.int_value);
    assign length        = res_reg.length;
    assign depth         = res_reg.depth;
    assign arrays_closed = res_reg.closed;
    assign message_done  = res_reg.msg_done;
    assign error_code    = res_reg.err;

    // An error event always carries a nonzero code
    `RSP_ASSERT_IMP(a_err_code, clk, rst_n,
        out_valid_reg && res_reg.ev == EV_ERROR, res_reg.err != ERR_NONE)
    // A finished top-level message closes every array it sat in
    `RSP_ASSERT_IMP(a_msg_close, clk, rst_n,
        out_valid_reg && res_reg.ev == EV_DONE && res_reg.msg_done,
        res_reg.closed == res_reg.depth)
    // A clear command yields an empty event on the next cycle
    `RSP_ASSERT_NEXT(a_clear_none, clk, rst_n,
        fire && s1_cmd_reg, out_valid_reg && res_reg.ev == EV_NONE)

endmodule

`default_nettype wire

FILE: rtl/rsp_stack.sv
// ---------------------------------------------------------------------------
// RESP array stack
// Remaining element counts of open arrays, with the close cascade search.
// ---------------------------------------------------------------------------
`default_nettype none

module rsp_stack #(
    parameter int STACK_DEPTH = 16,
    parameter int LEN_BITS    = 32,
    parameter int LVL_W       = $clog2(STACK_DEPTH + 1)
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  rsp_pkg::stk_ctl_t    ctl,
    input  wire  [LEN_BITS-1:0]  push_count,
    output logic [LVL_W-1:0]     level,
    output logic [LVL_W-1:0]     closed,
    output rsp_pkg::stk_stat_t   stat
);
    import rsp_pkg::*;

    localparam int IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    logic [LVL_W-1:0]       level_reg;
    logic [STACK_DEPTH-1:0] one_reg;
    logic [LEN_BITS-1:0]    count_reg [STACK_DEPTH];

    logic                   found;
    logic [IDX_W-1:0]       hz;
    logic [LVL_W-1:0]       level_after;
    logic [LEN_BITS-1:0]    dec_val;
    logic [IDX_W-1:0]       top_idx;

    // Highest open level whose count does not reach zero stops the cascade
    always_comb
    begin
        found = 1'b0;
        hz    = '0;
        for (int j = 0; j < STACK_DEPTH; j++)
        begin
            if (j < int'(level_reg) && !one_reg[j])
            begin
                found = 1'b1;
                hz    = IDX_W'(j);
            end
        end
        level_after = found ? (LVL_W'(hz) + LVL_W'(1)) : '0;
        dec_val     = count_reg[hz] - LEN_BITS'(1);
        top_idx     = level_reg[IDX_W-1:0];
    end

    assign level        = level_reg;
    assign closed       = level_reg - level_after;
    assign stat.full    = (level_reg >= LVL_W'(STACK_DEPTH));
    assign stat.drained = !found;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= '0;
            one_reg   <= '0;
        end
        else if (ctl.clear)
        begin
            level_reg <= '0;
        end
        else if (ctl.push)
        begin
            one_reg[top_idx] <= (push_count == LEN_BITS'(1));
            level_reg        <= level_reg + LVL_W'(1);
        end
        else if (ctl.complete)
        begin
            level_reg <= level_after;
            if (found)
            begin
                one_reg[hz] <= (dec_val == LEN_BITS'(1));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!ctl.clear && ctl.push)
        begin
            count_reg[top_idx] <= push_count;
        end
        else if (!ctl.clear && ctl.complete && found)
        begin
            count_reg[hz] <= dec_val;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/rsp_engine.sv
// ---------------------------------------------------------------------------
// RESP parse engine
// Per-byte phase logic, line accumulators and result formation.
// ---------------------------------------------------------------------------
`default_nettype none

module rsp_engine #(
    parameter int STACK_DEPTH = 16,
    parameter int LEN_BITS    = 32
) (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                fire,
    input  wire                cmd,
    input  wire  [7:0]         byte_in,
    output rsp_pkg::result_t   res
);
    import rsp_pkg::*;

    localparam int LVL_W = $clog2(STACK_DEPTH + 1);

    phase_t               phase_reg, phase_next;
    kind_t                kind_reg, kind_next;
    logic [LEN_BITS-1:0]  count_reg, count_next;
    logic                 seen_reg, seen_next;
    logic [INT_W-1:0]     acc_reg, acc_next;
    sign_t                sign_reg, sign_next;
    logic [LEN_BITS-1:0]  recv_reg, recv_next;
    logic                 halted_reg, halted_next;

    stk_ctl_t             sctl;
    stk_stat_t            sstat;
    logic [LVL_W-1:0]     level;
    logic [LVL_W-1:0]     closed;

    logic [3:0]           digit;
    logic                 is_digit;
    logic [LEN_BITS+3:0]  count_wide;
    logic [INT_W-1:0]     acc_x10;
    logic [LEN_BITS-1:0]  lenmax;

    rsp_stack #(
        .STACK_DEPTH (STACK_DEPTH),
        .LEN_BITS    (LEN_BITS),
        .LVL_W       (LVL_W)
    ) u_stack (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (sctl),
        .push_count (count_reg),
        .level      (level),
        .closed     (closed),
        .stat       (sstat)
    );

    assign lenmax     = '1;
    assign digit      = byte_in[3:0] - CH_ZERO[3:0];
    assign is_digit   = (byte_in >= CH_ZERO) && (byte_in <= CH_NINE);
    assign count_wide = ({4'b0, count_reg} << 3) + ({4'b0, count_reg} << 1)
                        + (LEN_BITS + 4)'(digit);
    assign acc_x10    = (acc_reg << 3) + (acc_reg << 1);

    always_comb
    begin
        phase_next  = phase_reg;
        kind_next   = kind_reg;
        count_next  = count_reg;
        seen_next   = seen_reg;
        acc_next    = acc_reg;
        sign_next   = sign_reg;
        recv_next   = recv_reg;
        halted_next = halted_reg;
        sctl        = '0;
        res         = '0;

        if (cmd)
        begin
            phase_next  = PH_TYPE;
            kind_next   = K_SIMPLE;
            count_next  = '0;
            seen_next   = 1'b0;
            acc_next    = '0;
            sign_next   = SIGN_NONE;
            recv_next   = '0;
            halted_next = 1'b0;
            sctl.clear  = 1'b1;
        end
        else if (halted_reg)
        begin
            res.ev  = EV_ERROR;
            res.err = ERR_HALTED;
        end
        else
        begin
            unique case (phase_reg)
                PH_TYPE:
                begin
                    count_next = '0;
                    seen_next  = 1'b0;
                    acc_next   = '0;
                    sign_next  = SIGN_NONE;
                    recv_next  = '0;
                    priority if (byte_in == CH_PLUS)
                    begin
                        kind_next = K_SIMPLE; phase_next = PH_LINE;
                    end
                    else if (byte_in == CH_MINUS)
                    begin
                        kind_next = K_ERRSTR; phase_next = PH_LINE;
                    end
                    else if (byte_in == CH_COLON)
                    begin
                        kind_next = K_INT; phase_next = PH_LINE;
                    end
                    else if (byte_in == CH_DOLLAR)
                    begin
                        kind_next = K_BULK; phase_next = PH_SIZE;
                    end
                    else if (byte_in == CH_STAR)
                    begin
                        kind_next = K_ARRAY; phase_next = PH_SIZE;
                    end
                    else
                    begin
                        res.ev = EV_ERROR; res.err = ERR_TYPE;
                    end
                end
                PH_LINE:
                begin
                    priority if (byte_in == CH_CR)
                    begin
                        phase_next = PH_END_LF;
                    end
                    else if (kind_reg == K_INT)
                    begin
                        priority if (byte_in == CH_MINUS)
                        begin
                            if (sign_reg != SIGN_NONE)
                            begin
                                res.ev = EV_ERROR; res.err = ERR_INT;
                            end
                            else
                            begin
                                sign_next = SIGN_MINUS;
                            end
                        end
                        else if (is_digit)
                        begin
                            if (sign_reg == SIGN_MINUS)
                            begin
                                acc_next = acc_x10 - INT_W'(digit);
                            end
                            else
                            begin
                                sign_next = SIGN_PLUS;
                                acc_next  = acc_x10 + INT_W'(digit);
                            end
                        end
                        else
                        begin
                            res.ev = EV_ERROR; res.err = ERR_INT;
                        end
                    end
                    else
                    begin
                        res.ev      = EV_PAYLOAD;
                        res.payload = byte_in;
                        res.kind    = kind_reg;
                    end
                end
                PH_SIZE:
                begin
                    priority if (byte_in == CH_MINUS)
                    begin
                        if (seen_reg)
                        begin
                            res.ev = EV_ERROR; res.err = ERR_SIZE;
                        end
                        else
                        begin
                            phase_next = PH_NIL;
                        end
                    end
                    else if (byte_in == CH_CR)
                    begin
                        if (!seen_reg)
                        begin
                            res.ev = EV_ERROR; res.err = ERR_SIZE;
                        end
                        else
                        begin
                            phase_next = PH_SIZE_LF;
                        end
                    end
                    else if (is_digit)
                    begin
                        if (count_wide > {4'b0, lenmax})
                        begin
                            res.ev = EV_ERROR; res.err = ERR_LENGTH;
                        end
                        else
                        begin
                            count_next = count_wide[LEN_BITS-1:0];
                            seen_next  = 1'b1;
                        end
                    end
                    else
                    begin
                        res.ev = EV_ERROR; res.err = ERR_SIZE;
                    end
                end
                PH_SIZE_LF:
                begin
                    priority if (byte_in != CH_LF)
                    begin
                        res.ev = EV_ERROR; res.err = ERR_TERM;
                    end
                    else if (kind_reg == K_ARRAY && count_reg == '0)
                    begin
                        res.ev       = EV_DONE;
                        res.kind     = K_ARRAY;
                        res.depth    = DEPTH_OUT_W'(level);
                        res.closed   = DEPTH_OUT_W'(closed);
                        res.msg_done = sstat.drained;
                        sctl.complete = 1'b1;
                        phase_next   = PH_TYPE;
                    end
                    else if (kind_reg == K_ARRAY && sstat.full)
                    begin
                        res.ev = EV_ERROR; res.err = ERR_STACK;
                    end
                    else if (kind_reg == K_ARRAY)
                    begin
                        res.ev     = EV_OPEN;
                        res.kind   = K_ARRAY;
                        res.length = LEN_OUT_W'(count_reg);
                        res.depth  = DEPTH_OUT_W'(level);
                        sctl.push  = 1'b1;
                        phase_next = PH_TYPE;
                    end
                    else
                    begin
                        recv_next  = '0;
                        phase_next = PH_BULK;
                    end
                end
                PH_NIL:
                begin
                    if (byte_in != CH_ONE)
                    begin
                        res.ev = EV_ERROR; res.err = ERR_SIZE;
                    end
                    else
                    begin
                        phase_next = PH_NIL_CR;
                    end
                end
                PH_NIL_CR:
                begin
                    if (byte_in != CH_CR)
                    begin
                        res.ev = EV_ERROR; res.err = ERR_TERM;
                    end
                    else
                    begin
                        phase_next = PH_NIL_LF;
                    end
                end
                PH_NIL_LF:
                begin
                    if (byte_in != CH_LF)
                    begin
                        res.ev = EV_ERROR; res.err = ERR_TERM;
                    end
                    else
                    begin
                        res.ev        = EV_DONE;
                        res.kind      = kind_reg;
                        res.is_null   = 1'b1;
                        res.depth     = DEPTH_OUT_W'(level);
                        res.closed    = DEPTH_OUT_W'(closed);
                        res.msg_done  = sstat.drained;
                        sctl.complete = 1'b1;
                        phase_next    = PH_TYPE;
                    end
                end
                PH_END_LF:
                begin
                    if (byte_in != CH_LF)
                    begin
                        res.ev = EV_ERROR; res.err = ERR_TERM;
                    end
                    else
                    begin
                        res.ev        = EV_DONE;
                        res.kind      = kind_reg;
                        res.int_value = (kind_reg == K_INT) ? acc_reg : '0;
                        res.length    = (kind_reg == K_BULK)
                                        ? LEN_OUT_W'(count_reg) : '0;
                        res.depth     = DEPTH_OUT_W'(level);
                        res.closed    = DEPTH_OUT_W'(closed);
                        res.msg_done  = sstat.drained;
                        sctl.complete = 1'b1;
                        phase_next    = PH_TYPE;
                    end
                end
                PH_BULK:
                begin
                    if (recv_reg >= count_reg)
                    begin
                        if (byte_in != CH_CR)
                        begin
                            res.ev = EV_ERROR; res.err = ERR_TERM;
                        end
                        else
                        begin
                            phase_next = PH_END_LF;
                        end
                    end
                    else
                    begin
                        recv_next   = recv_reg + LEN_BITS'(1);
                        res.ev      = EV_PAYLOAD;
                        res.payload = byte_in;
                        res.kind    = K_BULK;
                    end
                end
                default:
                begin
                    phase_next = PH_TYPE;
                end
            endcase
            if (res.ev == EV_ERROR)
            begin
                halted_next = 1'b1;
            end
        end

        // Hold all state and the stack unless a transaction is processed
        if (!fire)
        begin
            sctl = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_TYPE;
            kind_reg   <= K_SIMPLE;
            count_reg  <= '0;
            seen_reg   <= 1'b0;
            acc_reg    <= '0;
            sign_reg   <= SIGN_NONE;
            recv_reg   <= '0;
            halted_reg <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg  <= phase_next;
            kind_reg   <= kind_next;
            count_reg  <= count_next;
            seen_reg   <= seen_next;
            acc_reg    <= acc_next;
            sign_reg   <= sign_next;
            recv_reg   <= recv_next;
            halted_reg <= halted_next;
        end
    end

endmodule

`default_nettype wire

FILE: bench/resp_stream_parser_core_tb.sv
// ---------------------------------------------------------------------------
// RESP2 stream parser core testbench
// Drives RESP2 byte streams through the parser with random idle gaps on both
// channels and compares every event against a cycle-free software parser.
// ---------------------------------------------------------------------------
`default_nettype none

module resp_stream_parser_core_tb;
    import rsp_pkg::*;

    localparam int   DEPTH_MAX  = 16;
    localparam int   WDOG_LIMIT = 4000;
    localparam int   N_RANDOM   = 850;
    localparam logic CMD_PARSE  = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    typedef struct packed {
        event_t      ev;
        logic [7:0]  payload;
        kind_t       kind;
        logic        is_null;
        logic [63:0] int_value;
        logic [31:0] length;
        logic [4:0]  depth;
        logic [4:0]  closed;
        logic        msg_done;
        err_t        err;
    } parse_event_t;

    // One row of the directed table: a byte, plus an optional typed-in event.
    typedef struct {
        logic         cmd;
        logic [7:0]   b;
        logic         fixed;
        parse_event_t want;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic command = 1'b0;
    logic [7:0] data_byte = 8'h00;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [2:0] event_res;
    logic [7:0] payload_byte;
    logic [2:0] value_kind;
    logic is_null;
    logic signed [63:0] int_value;
    logic [31:0] length;
    logic [4:0] depth;
    logic [4:0] arrays_closed;
    logic message_done;
    logic [2:0] error_code;

    always #4 clk = ~clk;

    resp_stream_parser_core u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .command(command), .data_byte(data_byte),
        .out_valid(out_valid), .out_ready(out_ready),
        .event_res(event_res), .payload_byte(payload_byte),
        .value_kind(value_kind), .is_null(is_null),
        .int_value(int_value), .length(length), .depth(depth),
        .arrays_closed(arrays_closed), .message_done(message_done),
        .error_code(error_code)
    );

    // -----------------------------------------------------------------------
    // Software parser state
    // -----------------------------------------------------------------------
    phase_t      sw_phase;
    kind_t       sw_kind;
    logic [63:0] sw_count;
    logic        sw_count_seen;
    logic [63:0] sw_int;
    sign_t       sw_sign;
    logic [63:0] sw_bulk_got;
    logic [63:0] sw_remaining [DEPTH_MAX];
    int          sw_level;
    logic        sw_halted;

    parse_event_t pending_events [$];
    int  errors = 0;
    int  n_events = 0;
    int  n_msgs = 0;
    int  n_errs = 0;
    int  idle_cycles = 0;
    bit  stall_enable = 1'b1;

    function automatic void parser_clear();
        sw_phase = PH_TYPE;
        sw_kind = K_SIMPLE;
        sw_count = '0;
        sw_count_seen = 1'b0;
        sw_int = '0;
        sw_sign = SIGN_NONE;
        sw_bulk_got = '0;
        sw_level = 0;
        sw_halted = 1'b0;
    endfunction

    function automatic parse_event_t fail_event(err_t code);
        parse_event_t e;
        e = '0;
        sw_halted = 1'b1;
        e.ev = EV_ERROR;
        e.err = code;
        return e;
    endfunction

    // Finish a value: pop every enclosing array that it completes.
    function automatic parse_event_t finish_value(kind_t k, logic nul,
                                                  logic [63:0] iv, logic [63:0] len);
        parse_event_t e;
        int n;
        e = '0;
        n = 0;
        e.ev = EV_DONE;
        e.kind = k;
        e.is_null = nul;
        e.int_value = iv;
        e.length = len[31:0];
        e.depth = sw_level[4:0];
        while (sw_level > 0) begin
            if (sw_remaining[sw_level-1] - 1 != 0) begin
                sw_remaining[sw_level-1] -= 1;
                break;
            end
            sw_level--;
            n++;
        end
        e.closed = n[4:0];
        e.msg_done = (sw_level == 0);
        sw_phase = PH_TYPE;
        return e;
    endfunction

    function automatic parse_event_t parse_byte(logic cmd, logic [7:0] c);
        parse_event_t e;
        logic [63:0] d;
        logic [63:0] lenmax;
        e = '0;
        lenmax = (64'd1 << 32) - 1;
        d = {56'd0, c - CH_ZERO};
        if (cmd == CMD_CLEAR) begin
            parser_clear();
            return e;
        end
        if (sw_halted)
            return fail_event(ERR_HALTED);
        case (sw_phase)
            PH_TYPE:
            begin
                sw_count = '0;
                sw_count_seen = 1'b0;
                sw_int = '0;
                sw_sign = SIGN_NONE;
                sw_bulk_got = '0;
                if (c == CH_PLUS) begin sw_kind = K_SIMPLE; sw_phase = PH_LINE; end
                else if (c == CH_MINUS) begin sw_kind = K_ERRSTR; sw_phase = PH_LINE; end
                else if (c == CH_COLON) begin sw_kind = K_INT; sw_phase = PH_LINE; end
                else if (c == CH_DOLLAR) begin sw_kind = K_BULK; sw_phase = PH_SIZE; end
                else if (c == CH_STAR) begin sw_kind = K_ARRAY; sw_phase = PH_SIZE; end
                else return fail_event(ERR_TYPE);
            end
            PH_LINE:
            begin
                if (c == CH_CR) begin
                    sw_phase = PH_END_LF;
                end else if (sw_kind == K_INT) begin
                    if (c == CH_MINUS) begin
                        if (sw_sign != SIGN_NONE) return fail_event(ERR_INT);
                        sw_sign = SIGN_MINUS;
                    end else if (c >= CH_ZERO && c <= CH_NINE) begin
                        if (sw_sign == SIGN_NONE) sw_sign = SIGN_PLUS;
                        sw_int = sw_int * 10;
                        if (sw_sign == SIGN_PLUS) sw_int += d; else sw_int -= d;
                    end else begin
                        return fail_event(ERR_INT);
                    end
                end else begin
                    e.ev = EV_PAYLOAD;
                    e.payload = c;
                    e.kind = sw_kind;
                end
            end
            PH_SIZE:
            begin
                if (c == CH_MINUS) begin
                    if (sw_count_seen) return fail_event(ERR_SIZE);
                    sw_phase = PH_NIL;
                end else if (c == CH_CR) begin
                    if (!sw_count_seen) return fail_event(ERR_SIZE);
                    sw_phase = PH_SIZE_LF;
                end else if (c >= CH_ZERO && c <= CH_NINE) begin
                    if (sw_count > (lenmax - d) / 10) return fail_event(ERR_LENGTH);
                    sw_count = sw_count * 10 + d;
                    sw_count_seen = 1'b1;
                end else begin
                    return fail_event(ERR_SIZE);
                end
            end
            PH_SIZE_LF:
            begin
                if (c != CH_LF) return fail_event(ERR_TERM);
                if (sw_kind == K_ARRAY) begin
                    if (sw_count == 0) return finish_value(K_ARRAY, 1'b0, '0, '0);
                    if (sw_level >= DEPTH_MAX) return fail_event(ERR_STACK);
                    e.ev = EV_OPEN;
                    e.kind = K_ARRAY;
                    e.length = sw_count[31:0];
                    e.depth = sw_level[4:0];
                    sw_remaining[sw_level] = sw_count;
                    sw_level++;
                    sw_phase = PH_TYPE;
                end else begin
                    sw_bulk_got = '0;
                    sw_phase = PH_BULK;
                end
            end
            PH_NIL:
            begin
                if (c != CH_ONE) return fail_event(ERR_SIZE);
                sw_phase = PH_NIL_CR;
            end
            PH_NIL_CR:
            begin
                if (c != CH_CR) return fail_event(ERR_TERM);
                sw_phase = PH_NIL_LF;
            end
            PH_NIL_LF:
            begin
                if (c != CH_LF) return fail_event(ERR_TERM);
                return finish_value(sw_kind, 1'b1, '0, '0);
            end
            PH_END_LF:
            begin
                if (c != CH_LF) return fail_event(ERR_TERM);
                return finish_value(sw_kind, 1'b0,
                                    (sw_kind == K_INT) ? sw_int : 64'd0,
                                    (sw_kind == K_BULK) ? sw_count : 64'd0);
            end
            PH_BULK:
            begin
                if (sw_bulk_got >= sw_count) begin
                    if (c != CH_CR) return fail_event(ERR_TERM);
                    sw_phase = PH_END_LF;
                end else begin
                    sw_bulk_got++;
                    e.ev = EV_PAYLOAD;
                    e.payload = c;
                    e.kind = K_BULK;
                end
            end
            default: sw_phase = PH_TYPE;
        endcase
        return e;
    endfunction

    // -----------------------------------------------------------------------
    // Input driver: hold valid and payload until the transaction is taken.
    // Valid stays high between back-to-back bytes; drop it for an idle gap.
    // -----------------------------------------------------------------------
    task automatic send_byte(logic cmd, logic [7:0] b, bit fixed, parse_event_t want);
        parse_event_t e;
        int gap;
        if (stall_enable && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 7);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        command <= cmd;
        data_byte <= b;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        e = parse_byte(cmd, b);
        if (fixed && e !== want) begin
            $display("%0t directed row disagrees: table %h parser %h", $time, want, e);
            errors++;
        end
        pending_events.insert(pending_events.size(), e);
        @(negedge clk);
    endtask

    // Drop valid once the sender has nothing more to offer for now.
    task automatic drop_valid();
        in_valid <= 1'b0;
    endtask

    task automatic send_str(string s);
        parse_event_t z;
        z = '0;
        foreach (s[i]) send_byte(CMD_PARSE, s[i], 1'b0, z);
    endtask

    task automatic wait_drained();
        while (pending_events.size() != 0) @(negedge clk);
    endtask

    // -----------------------------------------------------------------------
    // Output side: random backpressure, compare each transaction in order.
    // -----------------------------------------------------------------------
    int stall_left = 0;
    always @(negedge clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_ready <= 1'b0;
        end else if (stall_enable && $urandom_range(0, 6) == 0) begin
            stall_left <= $urandom_range(0, 6);
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        parse_event_t want;
        parse_event_t got;
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WDOG_LIMIT) begin
                $display("%0t watchdog: no transaction for %0d cycles", $time, WDOG_LIMIT);
                $display("FAIL resp_stream_parser_core");
                $finish;
            end
            if (out_valid && out_ready) begin
                got = {event_t'(event_res), payload_byte, kind_t'(value_kind), is_null,
                       int_value, length, depth, arrays_closed, message_done,
                       err_t'(error_code)};
                if (pending_events.size() == 0) begin
                    $display("%0t unexpected event: actual %h", $time, got);
                    errors++;
                end else begin
                    want = pending_events.pop_front();
                    n_events++;
                    if (got.msg_done) n_msgs++;
                    if (got.ev == EV_ERROR) n_errs++;
                    if (got !== want) begin
                        $display("%0t mismatch: expected %h actual %h", $time, want, got);
                        errors++;
                    end
                end
            end
        end
    end

    // -----------------------------------------------------------------------
    // Random message generator, recursive through arrays.
    // -----------------------------------------------------------------------
    task automatic gen_digits(int unsigned v);
        send_str($sformatf("%0d", v));
    endtask

    task automatic gen_value(int lvl);
        int k;
        int n;
        k = $urandom_range(0, (lvl < 5) ? 5 : 3);
        case (k)
            0, 1:
            begin
                send_str(k == 0 ? "+" : "-");
                n = $urandom_range(0, 4);
                repeat (n) send_byte(CMD_PARSE, 8'($urandom_range(32, 126)), 1'b0, '0);
                send_str("\r\n");
            end
            2:
            begin
                send_str(":");
                if ($urandom_range(0, 1)) send_str("-");
                n = $urandom_range(0, 22);
                repeat (n) send_byte(CMD_PARSE, 8'($urandom_range(8'h30, 8'h39)), 1'b0, '0);
                send_str("\r\n");
            end
            3:
            begin
                if ($urandom_range(0, 7) == 0) send_str("$-1\r\n");
                else begin
                    n = $urandom_range(0, 5);
                    send_str("$");
                    gen_digits(n);
                    send_str("\r\n");
                    repeat (n) send_byte(CMD_PARSE, 8'($urandom), 1'b0, '0);
                    send_str("\r\n");
                end
            end
            default:
            begin
                if ($urandom_range(0, 7) == 0) send_str("*-1\r\n");
                else begin
                    n = $urandom_range(0, 3);
                    send_str("*");
                    gen_digits(n);
                    send_str("\r\n");
                    repeat (n) gen_value(lvl + 1);
                end
            end
        endcase
    endtask

    // Noise: a random byte, usually a syntax error (then one more), then clear.
    task automatic inject_noise();
        send_byte(CMD_PARSE, 8'($urandom), 1'b0, '0);
        if (sw_halted) send_byte(CMD_PARSE, 8'($urandom), 1'b0, '0);
        send_byte(CMD_CLEAR, 8'($urandom), 1'b0, '0);
    endtask

    // -----------------------------------------------------------------------
    // Main sequence
    // -----------------------------------------------------------------------
    row_t rows [$];
    int   sent_mark;

    function automatic parse_event_t err_ev(err_t code);
        parse_event_t e;
        e = '0;
        e.ev = EV_ERROR;
        e.err = code;
        return e;
    endfunction

    function automatic void add_row(logic cmd, logic [7:0] b, bit fixed, parse_event_t w);
        row_t r;
        r.cmd = cmd;
        r.b = b;
        r.fixed = fixed;
        r.want = w;
        rows.insert(rows.size(), r);
    endfunction

    initial begin
        parse_event_t none_ev;
        none_ev = '0;
        parser_clear();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed table: extremes, null forms, error codes and halting.
        add_row(CMD_PARSE, 8'h00, 1'b1, err_ev(ERR_TYPE));
        add_row(CMD_PARSE, 8'hFF, 1'b1, err_ev(ERR_HALTED));
        add_row(CMD_CLEAR, 8'hFF, 1'b1, none_ev);
        add_row(CMD_PARSE, CH_STAR, 1'b1, none_ev);
        add_row(CMD_PARSE, CH_MINUS, 1'b0, none_ev);
        add_row(CMD_PARSE, CH_ONE, 1'b0, none_ev);
        add_row(CMD_PARSE, CH_CR, 1'b0, none_ev);
        add_row(CMD_PARSE, CH_LF, 1'b0, none_ev);     // null array completes
        add_row(CMD_PARSE, CH_DOLLAR, 1'b0, none_ev);
        add_row(CMD_PARSE, CH_CR, 1'b1, err_ev(ERR_SIZE));  // no digits
        add_row(CMD_CLEAR, 8'h00, 1'b1, none_ev);
        add_row(CMD_PARSE, CH_COLON, 1'b0, none_ev);
        add_row(CMD_PARSE, CH_MINUS, 1'b0, none_ev);
        add_row(CMD_PARSE, CH_MINUS, 1'b1, err_ev(ERR_INT)); // second sign
        add_row(CMD_CLEAR, 8'h00, 1'b0, none_ev);
        add_row(CMD_PARSE, CH_PLUS, 1'b0, none_ev);
        add_row(CMD_PARSE, CH_CR, 1'b0, none_ev);
        add_row(CMD_PARSE, CH_PLUS, 1'b1, err_ev(ERR_TERM)); // missing line feed
        add_row(CMD_CLEAR, 8'h00, 1'b0, none_ev);
        foreach (rows[i]) send_byte(rows[i].cmd, rows[i].b, rows[i].fixed, rows[i].want);

        // Length overflow, empty array, empty integer, wrapping integer.
        send_str("$4294967296");
        send_byte(CMD_CLEAR, 8'h00, 1'b0, '0);
        send_str("*4294967295\r\n*0\r\n:\r\n:99999999999999999999999\r\n");
        send_str("$-2");
        send_byte(CMD_CLEAR, 8'h00, 1'b0, '0);
        send_str("$3-");
        send_byte(CMD_CLEAR, 8'h00, 1'b0, '0);
        send_str("$1\r\nAB");
        send_byte(CMD_CLEAR, 8'h00, 1'b0, '0);
        send_str("-x\r\n");
        // Fill the stack, then overflow it.
        repeat (DEPTH_MAX) send_str("*1\r\n");
        send_str("*1\r\n");
        send_byte(CMD_CLEAR, 8'h00, 1'b0, '0);
        repeat (DEPTH_MAX) send_str("*1\r\n");
        send_str(":-9223372036854775808\r\n");   // closes all sixteen arrays

        // Pause the sender until every result is back.
        drop_valid();
        wait_drained();

        // Random part: mostly well-formed messages, some noise.
        sent_mark = n_events + pending_events.size();
        while (sent_mark < N_RANDOM) begin
            if (sent_mark > N_RANDOM * 4 / 5) stall_enable = 1'b0;
            if ($urandom_range(0, 9) == 0) inject_noise();
            else gen_value(0);
            sent_mark = n_events + pending_events.size();
        end

        stall_enable = 1'b0;
        drop_valid();
        wait_drained();
        repeat (10) @(negedge clk);

        $display("Covered %0d events, %0d complete messages, %0d error events.",
                 n_events, n_msgs, n_errs);
        $display("Directed extremes, null forms, stack overflow, and random nesting.");
        if (errors == 0 && pending_events.size() == 0)
            $display("PASS resp_stream_parser_core");
        else
            $display("FAIL resp_stream_parser_core");
        $finish;
    end

endmodule

`default_nettype wire
